// ===== rtl/wide_char_unsigned_number_parser_assert.svh =====
// Assertion macros for the number parser checker.
// Both expect clk and rst in scope.
`ifndef WIDE_CHAR_UNSIGNED_NUMBER_PARSER_ASSERT_SVH
`define WIDE_CHAR_UNSIGNED_NUMBER_PARSER_ASSERT_SVH

// Checked at every edge, reset included.
`define WCUNP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define WCUNP_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== rtl/wcunp_pkg.sv =====
`timescale 1ns / 1ps
package wcunp_pkg;

  localparam int CHAR_W      = 21;
  localparam int S_TDATA_W   = 24;
  localparam int BASE_W      = 6;
  localparam int VALUE_OUT_W = 32;
  localparam int LEN_OUT_W   = 16;
  localparam int M_TDATA_W   = VALUE_OUT_W + LEN_OUT_W;
  localparam int PHASE_W     = 3;

  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_BLANK  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_START  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd4;

  localparam logic [CHAR_W-1:0] CH_TAB    = 21'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 21'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 21'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 21'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 21'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 21'h39;
  localparam logic [CHAR_W-1:0] CH_A_UP   = 21'h41;
  localparam logic [CHAR_W-1:0] CH_X_UP   = 21'h58;
  localparam logic [CHAR_W-1:0] CH_Z_UP   = 21'h5A;
  localparam logic [CHAR_W-1:0] CH_A_LO   = 21'h61;
  localparam logic [CHAR_W-1:0] CH_X_LO   = 21'h78;
  localparam logic [CHAR_W-1:0] CH_Z_LO   = 21'h7A;

  localparam logic [BASE_W-1:0] BASE_AUTO   = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [BASE_W-1:0] ALPHA_DIGIT = 6'd10;

endpackage

// ===== rtl/wide_char_unsigned_number_parser.sv =====
`timescale 1ns / 1ps
// A result is registered into the output register on the transfer of the character that ends
// the number, or into the skid register while an earlier result waits.
// Throughput: one character per cycle while s_axis_tready is high; the multiply-add by the base is combinational.
// Two result registers (output plus skid); s_axis_tready drops only while both are full.
// Reset (rst, synchronous): parser idle, number_base = 0, result registers empty.
module wide_char_unsigned_number_parser
  import wcunp_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [20:0] char_code, [23:21] zero
  input  logic                 s_axis_tuser,   // [0] first_char
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [31:0] parsed_value, [47:32] consumed_length
  output logic                 m_axis_tuser,   // [0] digits_found
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [BASE_W-1:0]    cfg_data
);

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  logic [BASE_W-1:0]     number_base;
  logic [PHASE_W-1:0]    phase, phase_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [BASE_W-1:0]     base, base_next;
  logic                  minus, minus_next;
  logic [COUNT_BITS-1:0] cnt, cnt_next;
  logic                  digit_seen, digit_seen_next;

  logic                  out_valid, skid_valid;
  logic [M_TDATA_W-1:0]  out_data, skid_data;
  logic                  out_flag, skid_flag;

  logic [CHAR_W-1:0]     c;
  logic                  first;
  logic                  accept, emit;
  logic [BASE_W-1:0]     dval;
  logic                  dval_ok;

  logic [PHASE_W-1:0]    ph_e;
  logic [VALUE_BITS-1:0] acc_e;
  logic [BASE_W-1:0]     base_e;
  logic                  minus_e;
  logic [COUNT_BITS-1:0] cnt_e;
  logic                  ds_e;

  logic                  run_start, run_digit;
  logic [VALUE_BITS-1:0] dig_acc, mac, res_value;
  logic [BASE_W-1:0]     dig_base;
  logic [COUNT_BITS-1:0] dig_cnt;
  logic                  dig_ds;
  logic [M_TDATA_W-1:0]  res_data;

  assign c      = s_axis_tdata[CHAR_W-1:0];
  assign first  = s_axis_tuser;
  assign accept = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = !skid_valid;
  assign cfg_ready     = 1'b1;

  always_comb begin
    dval    = '0;
    dval_ok = 1'b0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      dval    = BASE_W'(c - CH_ZERO);
      dval_ok = 1'b1;
    end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
      dval    = BASE_W'(c - CH_A_LO) + ALPHA_DIGIT;
      dval_ok = 1'b1;
    end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
      dval    = BASE_W'(c - CH_A_UP) + ALPHA_DIGIT;
      dval_ok = 1'b1;
    end
  end

  always_comb begin
    ph_e    = first ? PH_BLANK : phase;
    acc_e   = first ? '0 : acc;
    base_e  = first ? '0 : base;
    minus_e = first ? 1'b0 : minus;
    cnt_e   = first ? '0 : cnt;
    ds_e    = first ? 1'b0 : digit_seen;

    phase_next      = ph_e;
    acc_next        = acc_e;
    base_next       = base_e;
    minus_next      = minus_e;
    cnt_next        = cnt_e;
    digit_seen_next = ds_e;

    run_start = 1'b0;
    run_digit = 1'b0;
    dig_acc   = acc_e;
    dig_base  = base_e;
    dig_cnt   = cnt_e;
    dig_ds    = ds_e;
    emit      = 1'b0;

    unique case (ph_e)
      PH_BLANK: begin
        if (c == CH_SPACE || c == CH_TAB) begin
          cnt_next = sat_inc(cnt_e);
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          minus_next = (c == CH_MINUS);
          cnt_next   = sat_inc(cnt_e);
          phase_next = PH_START;
        end else begin
          run_start = 1'b1;
        end
      end
      PH_START: run_start = 1'b1;
      PH_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) begin
          cnt_next   = sat_inc(sat_inc(cnt_e));
          base_next  = BASE_HEX;
          phase_next = PH_DIGITS;
        end else begin
          run_digit = 1'b1;
          dig_base  = (base_e == BASE_AUTO) ? BASE_OCT : base_e;
          dig_acc   = '0;
          dig_ds    = 1'b1;
          dig_cnt   = sat_inc(cnt_e);
        end
      end
      PH_DIGITS: run_digit = 1'b1;
      default: ;
    endcase

    if (run_start) begin
      if ((number_base == BASE_AUTO || number_base == BASE_HEX) && c == CH_ZERO) begin
        phase_next = PH_ZERO;
        base_next  = number_base;
      end else begin
        run_digit = 1'b1;
        dig_base  = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
      end
    end

    mac = VALUE_BITS'(dig_acc * VALUE_BITS'(dig_base)) + VALUE_BITS'(dval);

    if (run_digit) begin
      base_next = dig_base;
      if (dval_ok && dval < dig_base) begin
        acc_next        = mac;
        digit_seen_next = 1'b1;
        cnt_next        = sat_inc(dig_cnt);
        phase_next      = PH_DIGITS;
      end else begin
        acc_next        = dig_acc;
        digit_seen_next = dig_ds;
        cnt_next        = dig_cnt;
        phase_next      = PH_IDLE;
        emit            = 1'b1;
      end
    end

    res_value = minus_e ? (VALUE_BITS'(0) - dig_acc) : dig_acc;
    res_data  = {(dig_ds ? LEN_OUT_W'(dig_cnt) : LEN_OUT_W'(0)), VALUE_OUT_W'(res_value)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_AUTO;
    end else if (cfg_valid && cfg_ready) begin
      number_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      base       <= '0;
      minus      <= 1'b0;
      cnt        <= '0;
      digit_seen <= 1'b0;
    end else if (accept) begin
      acc        <= acc_next;
      base       <= base_next;
      minus      <= minus_next;
      cnt        <= cnt_next;
      digit_seen <= digit_seen_next;
    end
  end

  // output register plus one skid entry; order is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && m_axis_tready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_flag   <= skid_flag;
        skid_valid <= 1'b0;
      end else if (accept && emit) begin
        out_data <= res_data;
        out_flag <= dig_ds;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (accept && emit) begin
        out_data  <= res_data;
        out_flag  <= dig_ds;
        out_valid <= 1'b1;
      end
    end else if (accept && emit) begin
      skid_data  <= res_data;
      skid_flag  <= dig_ds;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_flag;

endmodule

// ===== rtl/wcunp_checker.sv =====
`timescale 1ns / 1ps
`include "wide_char_unsigned_number_parser_assert.svh"
module wcunp_checker
  import wcunp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  `WCUNP_ASSERT_ALWAYS(a_reset_empty, rst |=> (!m_axis_tvalid && s_axis_tready), "output not empty after reset")
  `WCUNP_ASSERT_RUN(a_no_digits_zero, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0), "nonzero result without digits")
  `WCUNP_ASSERT_RUN(a_stall_needs_result, !s_axis_tready |-> m_axis_tvalid, "input stalled with no result pending")
  `WCUNP_ASSERT_RUN(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

endmodule

bind wide_char_unsigned_number_parser wcunp_checker u_wcunp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/tb_wide_char_unsigned_number_parser.sv =====
`timescale 1ns / 1ps
module tb_wide_char_unsigned_number_parser;
  import wcunp_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  localparam logic [CHAR_W-1:0] CH_NUL   = 21'h00;
  localparam logic [CHAR_W-1:0] CH_BANG  = 21'h21;
  localparam logic [CHAR_W-1:0] CH_COMMA = 21'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 21'h2E;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 21'h3B;
  localparam logic [CHAR_W-1:0] CH_G_LO  = 21'h67;
  localparam logic [CHAR_W-1:0] CH_MAX   = 21'h10FFFF;

  localparam logic [BASE_W-1:0] BASE_ONE = 6'd1;
  localparam logic [BASE_W-1:0] BASE_BIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_36  = 6'd36;
  localparam logic [BASE_W-1:0] BASE_37  = 6'd37;
  localparam logic [BASE_W-1:0] BASE_TOP = 6'd63;

  typedef struct packed {
    logic [VALUE_OUT_W-1:0] value;
    logic [LEN_OUT_W-1:0]   length;
    logic                   found;
  } number_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [BASE_W-1:0]    cfg_data = '0;

  wide_char_unsigned_number_parser #(
    .VALUE_BITS(32),
    .COUNT_BITS(16)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // parser image
  logic [BASE_W-1:0]      base_reg = BASE_AUTO;
  logic [PHASE_W-1:0]     phase = PH_IDLE;
  logic [VALUE_OUT_W-1:0] acc = '0;
  logic [BASE_W-1:0]      radix = '0;
  logic                   neg = 1'b0;
  logic                   seen = 1'b0;
  logic [LEN_OUT_W-1:0]   count = '0;

  number_t expected_numbers[$];

  int send_gap = 0;
  int recv_stall = 0;
  int errors = 0;
  int sent_chars = 0;
  int numbers_checked = 0;
  int quiet = 0;

  function automatic int char_digit(logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_A_LO && c <= CH_Z_LO) return int'(c - CH_A_LO) + 10;
    if (c >= CH_A_UP && c <= CH_Z_UP) return int'(c - CH_A_UP) + 10;
    return 99;
  endfunction

  function automatic void bump_count();
    if (count != '1) count = count + 1'b1;
  endfunction

  function automatic void take_digit(logic [CHAR_W-1:0] c);
    int d;
    number_t r;
    d = char_digit(c);
    if (d != 99 && d < int'(radix)) begin
      acc = acc * VALUE_OUT_W'(radix) + VALUE_OUT_W'(d);
      seen = 1'b1;
      bump_count();
    end else begin
      r.value  = neg ? (VALUE_OUT_W'(0) - acc) : acc;
      r.length = seen ? count : '0;
      r.found  = seen;
      expected_numbers.push_back(r);
      phase = PH_IDLE;
    end
  endfunction

  function automatic void open_number(logic [CHAR_W-1:0] c);
    radix = base_reg;
    if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CH_ZERO) begin
      phase = PH_ZERO;
    end else begin
      if (radix == BASE_AUTO) radix = BASE_DEC;
      phase = PH_DIGITS;
      take_digit(c);
    end
  endfunction

  function automatic void parse_char(logic [CHAR_W-1:0] c, logic first);
    if (first) begin
      phase = PH_BLANK;
      acc   = '0;
      radix = '0;
      neg   = 1'b0;
      count = '0;
      seen  = 1'b0;
    end
    case (phase)
      PH_BLANK: begin
        if (c == CH_SPACE || c == CH_TAB) begin
          bump_count();
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg = (c == CH_MINUS);
          bump_count();
          phase = PH_START;
        end else begin
          open_number(c);
        end
      end
      PH_START: open_number(c);
      PH_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) begin
          bump_count();
          bump_count();
          radix = BASE_HEX;
          phase = PH_DIGITS;
        end else begin
          if (radix == BASE_AUTO) radix = BASE_OCT;
          acc  = '0;
          seen = 1'b1;
          bump_count();
          phase = PH_DIGITS;
          take_digit(c);
        end
      end
      PH_DIGITS: take_digit(c);
      default: ;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(int d);
    if (d < 10) return CH_ZERO + CHAR_W'(d);
    return ($urandom_range(1) ? CH_A_LO : CH_A_UP) + CHAR_W'(d - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] noise_char();
    case ($urandom_range(3))
      0: return CHAR_W'($urandom_range(0, CH_MAX));
      1: return CHAR_W'($urandom_range(0, 127));
      2: return digit_char($urandom_range(0, 35));
      default: return $urandom_range(1) ? CH_SPACE : CH_MINUS;
    endcase
  endfunction

  // starts and ends at a falling edge
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic first);
    while ($urandom_range(99) < send_gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, c};
    s_axis_tuser  <= first;
    do @(posedge clk); while (!s_axis_tready);
    parse_char(c, first);
    sent_chars++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(CHAR_W'(s[i]), i == 0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_numbers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] b);
    if (phase != PH_IDLE) send_char(CH_BANG, 1'b0);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= b;
    do @(posedge clk); while (!cfg_ready);
    base_reg = b;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_string();
    logic [CHAR_W-1:0] text[$];
    int kind, eff, n, cut;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 4)) send_char(noise_char(), $urandom_range(3) == 0);
      return;
    end
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    case ($urandom_range(2))
      1: text.push_back(CH_PLUS);
      2: text.push_back(CH_MINUS);
      default: ;
    endcase
    eff = (base_reg == BASE_AUTO) ? 10 : int'(base_reg);
    if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && $urandom_range(2) == 0) begin
      text.push_back(CH_ZERO);
      text.push_back($urandom_range(1) ? CH_X_LO : CH_X_UP);
      eff = 16;
    end else if (base_reg == BASE_AUTO && $urandom_range(3) == 0) begin
      text.push_back(CH_ZERO);
      eff = 8;
    end
    if (eff > 36) eff = 36;
    n = ($urandom_range(3) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6);
    repeat (n) text.push_back(digit_char($urandom_range(0, eff - 1)));
    case ($urandom_range(5))
      0: text.push_back(CH_NUL);
      1: text.push_back(CH_SPACE);
      2: text.push_back(CH_COMMA);
      3: text.push_back(CHAR_W'($urandom_range(128, CH_MAX)));
      4: text.push_back(eff < 36 ? digit_char(eff) : CH_SEMI);
      default: text.push_back(CH_DOT);
    endcase
    // cut short so the next mark lands mid-number
    cut = (kind < 22) ? $urandom_range(0, text.size() - 1) : text.size();
    for (int i = 0; i < cut; i++) send_char(text[i], i == 0);
    if ($urandom_range(7) == 0) send_char(noise_char(), 1'b0);
  endtask

  task automatic test_auto_base_strings();
    send_char(CH_A_LO, 1'b0);
    send_text(" \t-0x1F");
    send_char(CH_NUL, 1'b0);
    send_text("0x");
    send_char(CH_G_LO, 1'b0);
    send_text("+017");
    send_char(CH_MAX, 1'b0);
    send_text("12");
    send_text("9");
    send_char(CH_DOT, 1'b0);
    send_text("z");
  endtask

  task automatic test_random_strings(input int items, input int gap, input int stall);
    logic [BASE_W-1:0] bases[$];
    int start, next_switch, pick;
    bases = '{BASE_AUTO, BASE_ONE, BASE_BIN, BASE_OCT, BASE_DEC, BASE_HEX,
              BASE_36, BASE_37, BASE_TOP};
    send_gap   = gap;
    recv_stall = stall;
    start = sent_chars;
    next_switch = sent_chars;
    while (sent_chars - start < items) begin
      if (sent_chars >= next_switch) begin
        pick = $urandom_range(0, bases.size());
        write_base(pick < bases.size() ? bases[pick] : BASE_W'($urandom_range(0, 63)));
        next_switch = sent_chars + $urandom_range(25, 60);
      end
      random_string();
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    number_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_numbers.size() == 0) begin
        $error("unexpected result: parsed_value %0h consumed_length %0d digits_found %0b",
               m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tuser);
        errors++;
      end else begin
        want = expected_numbers.pop_front();
        numbers_checked++;
        if (m_axis_tdata[31:0] !== want.value) begin
          $error("parsed_value: expected %0h, got %0h", want.value, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[47:32] !== want.length) begin
          $error("consumed_length: expected %0d, got %0d", want.length, m_axis_tdata[47:32]);
          errors++;
        end
        if (m_axis_tuser !== want.found) begin
          $error("digits_found: expected %0b, got %0b", want.found, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_gap   = 38;
    recv_stall = 54;
    test_auto_base_strings();
    test_random_strings(170, 38, 54);
    test_random_strings(170, 54, 38);
    test_random_strings(170, 0, 0);

    if (phase != PH_IDLE) send_char(CH_BANG, 1'b0);
    wait_drained();
    repeat (10) @(negedge clk);

    $display("Sent %0d characters and checked %0d numbers across bases 0..63,", sent_chars,
             numbers_checked);
    $display("signs, 0x and octal prefixes, dropped strings and overflow.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
